// ----- src/cqe_pkg.sv -----
package cqe_pkg;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_DUMP   = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OVERFLOW = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [31:0] data_in;
    } in_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] data_out;
        logic               data_valid;
        logic               last;
    } out_t;

    typedef struct packed {
        logic valid;
        in_t  item;
    } cmd_slot_t;

endpackage

// ----- src/circular_queue_engine_top.sv -----
// Path: a command passes the front buffer register, the back end and the result buffer
// register; a delete or dump result also waits for a registered memory read.
// Flow: an insert frees the back end for the next command, a delete holds it for its
// read; a dump gives one word per cycle from the single read port unless stalled.
// Reset: rst_n is asynchronous, active low; it empties the queue and both handshake
// buffers. Stored words are not cleared.
module circular_queue_engine_top #(
    parameter int DEPTH = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  cqe_pkg::in_t  item,
    output logic          empty,
    input  logic          pop,
    output cqe_pkg::out_t result
);
    import cqe_pkg::*;

    cmd_slot_t cq;
    logic      cq_pop;
    logic      res_room;
    logic      res_push;
    out_t      res;

    cqe_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .cq     (cq),
        .cq_pop (cq_pop)
    );

    cqe_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cq       (cq),
        .cq_pop   (cq_pop),
        .res_room (res_room),
        .res_push (res_push),
        .res      (res)
    );

    cqe_res_q u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res),
        .room    (res_room),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

    a_word_only_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && result.data_valid |-> result.status == ST_OK)
        else $error("word transfer with non-ok status");

    a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && result.status != ST_OK |-> result.last)
        else $error("error status not marked last");

    a_no_word_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !result.data_valid |-> result.data_out == '0)
        else $error("data_out not zero without a word");

    a_no_push_without_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> res_room)
        else $error("result written into a full buffer");

endmodule

// ----- src/cqe_front.sv -----
module cqe_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  cqe_pkg::in_t      item,
    output cqe_pkg::cmd_slot_t cq,
    input  logic              cq_pop
);
    import cqe_pkg::*;

    in_t        ent_reg [2];
    logic       wr_reg;
    logic       wr_next;
    logic       rd_reg;
    logic       rd_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       keep;

    // drop items with an unused command code
    always_comb
    begin
        keep     = push && !full && (item.cmd inside {CMD_INSERT, CMD_DELETE, CMD_DUMP});
        wr_next  = wr_reg ^ keep;
        rd_next  = rd_reg ^ cq_pop;
        cnt_next = cnt_reg + 2'(keep) - 2'(cq_pop);
    end

    always_ff @(posedge clk)
    begin
        if (keep)
        begin
            ent_reg[wr_reg] <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    assign full     = (cnt_reg == 2'd2);
    assign cq.valid = (cnt_reg != 2'd0);
    assign cq.item  = ent_reg[rd_reg];

endmodule

// ----- src/cqe_res_q.sv -----
module cqe_res_q (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  cqe_pkg::out_t wr_data,
    output logic          room,
    output logic          empty,
    input  logic          pop,
    output cqe_pkg::out_t result
);
    import cqe_pkg::*;

    out_t       ent_reg [2];
    logic       wr_reg;
    logic       wr_next;
    logic       rd_reg;
    logic       rd_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       take;

    always_comb
    begin
        take     = pop && !empty;
        wr_next  = wr_reg ^ wr_en;
        rd_next  = rd_reg ^ take;
        cnt_next = cnt_reg + 2'(wr_en) - 2'(take);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ent_reg[wr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    assign room   = (cnt_reg != 2'd2);
    assign empty  = (cnt_reg == 2'd0);
    assign result = ent_reg[rd_reg];

endmodule

// ----- src/cqe_back.sv -----
module cqe_back #(
    parameter int DEPTH = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  cqe_pkg::cmd_slot_t cq,
    output logic               cq_pop,
    input  logic               res_room,
    output logic               res_push,
    output cqe_pkg::out_t      res
);
    import cqe_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DEL  = 2'd1;
    localparam logic [1:0] S_DUMP = 2'd2;

    logic signed [31:0] mem [DEPTH];
    logic signed [31:0] rd_q;

    logic [1:0]    state_reg;
    logic [1:0]    state_next;
    logic [AW-1:0] head_reg;
    logic [AW-1:0] head_next;
    logic [AW-1:0] tail_reg;
    logic [AW-1:0] tail_next;
    logic [AW-1:0] idx_reg;
    logic [AW-1:0] idx_next;
    logic [CW-1:0] occ_reg;
    logic [CW-1:0] occ_next;
    logic [CW-1:0] left_reg;
    logic [CW-1:0] left_next;

    logic          wr_en;
    logic          rd_en;
    logic [AW-1:0] rd_addr;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] idx);
        logic [AW-1:0] nxt;
        nxt = (idx == AW'(DEPTH - 1)) ? '0 : idx + AW'(1);
        return nxt;
    endfunction

    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        idx_next   = idx_reg;
        occ_next   = occ_reg;
        left_next  = left_reg;
        wr_en      = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = head_reg;
        cq_pop     = 1'b0;
        res_push   = 1'b0;
        res        = '{status: ST_OK, data_out: '0, data_valid: 1'b0, last: 1'b1};

        case (state_reg)
            S_IDLE:
            begin
                if (cq.valid && res_room)
                begin
                    cq_pop = 1'b1;
                    case (cq.item.cmd)
                        CMD_INSERT:
                        begin
                            res_push = 1'b1;
                            if (occ_reg == CW'(DEPTH))
                            begin
                                res.status = ST_OVERFLOW;
                            end
                            else
                            begin
                                wr_en     = 1'b1;
                                tail_next = wrap_inc(tail_reg);
                                occ_next  = occ_reg + CW'(1);
                            end
                        end
                        CMD_DELETE:
                        begin
                            if (occ_reg == '0)
                            begin
                                res_push   = 1'b1;
                                res.status = ST_EMPTY;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                head_next  = wrap_inc(head_reg);
                                occ_next   = occ_reg - CW'(1);
                                state_next = S_DEL;
                            end
                        end
                        CMD_DUMP:
                        begin
                            if (occ_reg == '0)
                            begin
                                res_push   = 1'b1;
                                res.status = ST_EMPTY;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                idx_next   = head_reg;
                                left_next  = occ_reg;
                                state_next = S_DUMP;
                            end
                        end
                        default:
                        begin
                            cq_pop = 1'b1;
                        end
                    endcase
                end
            end
            S_DEL:
            begin
                res_push       = 1'b1;
                res.data_out   = rd_q;
                res.data_valid = 1'b1;
                state_next     = S_IDLE;
            end
            S_DUMP:
            begin
                if (res_room)
                begin
                    res_push       = 1'b1;
                    res.data_out   = rd_q;
                    res.data_valid = 1'b1;
                    res.last       = (left_reg == CW'(1));
                    if (left_reg == CW'(1))
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        rd_en     = 1'b1;
                        rd_addr   = wrap_inc(idx_reg);
                        idx_next  = wrap_inc(idx_reg);
                        left_next = left_reg - CW'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[tail_reg] <= cq.item.data_in;
        end
        if (rd_en)
        begin
            rd_q <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            tail_reg  <= '0;
            idx_reg   <= '0;
            occ_reg   <= '0;
            left_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            idx_reg   <= idx_next;
            occ_reg   <= occ_next;
            left_reg  <= left_next;
        end
    end

endmodule

// ----- tb/sv/tb_circular_queue_engine_top.sv -----
`timescale 1ns / 1ps

module tb_circular_queue_engine_top;

    import cqe_pkg::*;

    localparam int         DEPTH       = 8;
    localparam int         IDLE_LIMIT  = 2000;
    localparam int         RANDOM_CMDS = 85;
    localparam int         SCRIPT_LEN  = 25;
    localparam logic [1:0] CMD_UNUSED  = 2'd3;

    typedef struct packed {
        in_t  cmd_item;
        logic pinned;
        out_t known_res;
    } script_row_t;

    logic clk    = 1'b0;
    logic rst_n  = 1'b0;
    logic push   = 1'b0;
    logic pop    = 1'b0;
    in_t  item   = '0;
    logic full;
    logic empty;
    out_t result;

    logic pinned_valid = 1'b0;
    out_t pinned_res   = '0;

    logic signed [31:0] ring_words [DEPTH];
    logic [2:0]         ring_head  = '0;
    logic [2:0]         ring_tail  = '0;
    logic [3:0]         ring_count = '0;

    out_t        pending_results [$];
    script_row_t script [SCRIPT_LEN];
    int          mismatch_count = 0;
    int          idle_cycles    = 0;
    int          send_burst     = 0;
    int          take_burst     = 0;

    circular_queue_engine_top #(.DEPTH(DEPTH)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    always #5 clk = ~clk;

    function automatic out_t fixed(logic [1:0] st, logic signed [31:0] w, logic v);
        out_t r;
        r.status     = st;
        r.data_out   = w;
        r.data_valid = v;
        r.last       = 1'b1;
        return r;
    endfunction

    function automatic script_row_t row(logic [1:0] c, logic signed [31:0] d, logic pin,
                                        out_t r);
        script_row_t s;
        s.cmd_item.cmd     = c;
        s.cmd_item.data_in = d;
        s.pinned           = pin;
        s.known_res        = r;
        return s;
    endfunction

    function automatic logic [2:0] next_slot(logic [2:0] idx);
        return (idx == 3'(DEPTH - 1)) ? 3'd0 : idx + 3'd1;
    endfunction

    function automatic int draw_wait(inout int burst);
        if (burst > 0)
        begin
            burst--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0)
            burst = $urandom_range(8, 20);
        return $urandom_range(0, 14);
    endfunction

    task automatic model_command(in_t it, logic keep);
        logic [2:0] idx;
        out_t       r;
        idx = ring_head;
        case (it.cmd)
            CMD_INSERT:
            begin
                if (ring_count == 4'(DEPTH))
                begin
                    r = fixed(ST_OVERFLOW, '0, 1'b0);
                end
                else
                begin
                    ring_words[ring_tail] = it.data_in;
                    ring_tail  = next_slot(ring_tail);
                    ring_count = ring_count + 4'd1;
                    r = fixed(ST_OK, '0, 1'b0);
                end
                if (keep)
                    pending_results.push_back(r);
            end
            CMD_DELETE:
            begin
                if (ring_count == 0)
                begin
                    r = fixed(ST_EMPTY, '0, 1'b0);
                end
                else
                begin
                    r = fixed(ST_OK, ring_words[ring_head], 1'b1);
                    ring_head  = next_slot(ring_head);
                    ring_count = ring_count - 4'd1;
                end
                if (keep)
                    pending_results.push_back(r);
            end
            CMD_DUMP:
            begin
                if (ring_count == 0)
                begin
                    if (keep)
                        pending_results.push_back(fixed(ST_EMPTY, '0, 1'b0));
                end
                else
                begin
                    for (int n = 0; n < ring_count; n++)
                    begin
                        r = fixed(ST_OK, ring_words[idx], 1'b1);
                        r.last = (n + 1 == ring_count);
                        if (keep)
                            pending_results.push_back(r);
                        idx = next_slot(idx);
                    end
                end
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic log_mismatch(string what, logic [35:0] got, logic [35:0] want);
        $display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic check_result(out_t got);
        out_t want;
        if (pending_results.size() == 0)
        begin
            log_mismatch("result with nothing pending", got, '0);
        end
        else
        begin
            want = pending_results.pop_front();
            if (got.status !== want.status)
                log_mismatch("status", 36'(got.status), 36'(want.status));
            if (got.data_out !== want.data_out)
                log_mismatch("data_out", 36'(unsigned'(got.data_out)),
                             36'(unsigned'(want.data_out)));
            if (got.data_valid !== want.data_valid)
                log_mismatch("data_valid", 36'(got.data_valid), 36'(want.data_valid));
            if (got.last !== want.last)
                log_mismatch("last", 36'(got.last), 36'(want.last));
        end
    endtask

    task automatic offer_command(in_t it, logic pin, out_t known);
        int gap;
        gap = draw_wait(send_burst);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push         <= 1'b1;
        item         <= it;
        pinned_valid <= pin;
        pinned_res   <= known;
        do @(posedge clk); while (full);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
            begin
                model_command(item, !pinned_valid);
                if (pinned_valid)
                    pending_results.push_back(pinned_res);
            end
            if (pop && !empty)
                check_result(result);
        end
    end

    initial
    begin
        int gap;
        wait (rst_n);
        forever
        begin
            gap = draw_wait(take_burst);
            if (gap > 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            do @(posedge clk); while (empty);
        end
    end

    initial
    begin
        wait (rst_n);
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("FAIL circular_queue_engine_top");
        $finish;
    end

    initial
    begin
        in_t it;
        int  phase;
        int  pick;
        int  ins_cut;
        int  del_cut;

        script[0]  = row(CMD_DELETE, 32'h0f0f_0f0f, 1'b1, fixed(ST_EMPTY, '0, 1'b0));
        script[1]  = row(CMD_DUMP,   32'hf0f0_f0f0, 1'b1, fixed(ST_EMPTY, '0, 1'b0));
        script[2]  = row(CMD_UNUSED, 32'hffff_ffff, 1'b0, '0);
        script[3]  = row(CMD_INSERT, 32'h8000_0000, 1'b1, fixed(ST_OK, '0, 1'b0));
        script[4]  = row(CMD_INSERT, 32'h7fff_ffff, 1'b1, fixed(ST_OK, '0, 1'b0));
        script[5]  = row(CMD_INSERT, 32'h0000_0000, 1'b1, fixed(ST_OK, '0, 1'b0));
        script[6]  = row(CMD_INSERT, 32'hffff_ffff, 1'b1, fixed(ST_OK, '0, 1'b0));
        script[7]  = row(CMD_INSERT, 32'h5555_5555, 1'b1, fixed(ST_OK, '0, 1'b0));
        script[8]  = row(CMD_INSERT, 32'haaaa_aaaa, 1'b1, fixed(ST_OK, '0, 1'b0));
        script[9]  = row(CMD_INSERT, 32'h0000_0001, 1'b1, fixed(ST_OK, '0, 1'b0));
        script[10] = row(CMD_INSERT, 32'h1234_5678, 1'b1, fixed(ST_OK, '0, 1'b0));
        script[11] = row(CMD_INSERT, 32'h0000_0063, 1'b1, fixed(ST_OVERFLOW, '0, 1'b0));
        script[12] = row(CMD_DUMP,   32'h7fff_ffff, 1'b0, '0);
        script[13] = row(CMD_UNUSED, 32'h0000_0000, 1'b0, '0);
        script[14] = row(CMD_DELETE, 32'hffff_ffff, 1'b1,
                         fixed(ST_OK, 32'h8000_0000, 1'b1));
        script[15] = row(CMD_DELETE, 32'h0000_0000, 1'b1,
                         fixed(ST_OK, 32'h7fff_ffff, 1'b1));
        script[16] = row(CMD_INSERT, 32'hdead_beef, 1'b1, fixed(ST_OK, '0, 1'b0));
        script[17] = row(CMD_INSERT, 32'hcafe_f00d, 1'b1, fixed(ST_OK, '0, 1'b0));
        script[18] = row(CMD_INSERT, 32'h0000_0002, 1'b1, fixed(ST_OVERFLOW, '0, 1'b0));
        script[19] = row(CMD_DUMP,   32'h8000_0000, 1'b0, '0);
        script[20] = row(CMD_DELETE, 32'h1111_1111, 1'b0, '0);
        script[21] = row(CMD_DELETE, 32'h2222_2222, 1'b0, '0);
        script[22] = row(CMD_DUMP,   32'h3333_3333, 1'b0, '0);
        script[23] = row(CMD_DELETE, 32'h4444_4444, 1'b0, '0);
        script[24] = row(CMD_DUMP,   32'h5555_5555, 1'b0, '0);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < SCRIPT_LEN; i++)
            offer_command(script[i].cmd_item, script[i].pinned, script[i].known_res);

        phase = 0;
        for (int i = 0; i < RANDOM_CMDS; i++)
        begin
            if (i % 16 == 0)
                phase = $urandom_range(0, 2);
            case (phase)
                0:
                begin
                    ins_cut = 75;
                    del_cut = 90;
                end
                1:
                begin
                    ins_cut = 35;
                    del_cut = 85;
                end
                default:
                begin
                    ins_cut = 50;
                    del_cut = 75;
                end
            endcase
            pick = $urandom_range(0, 99);
            if (pick < 5)
                it.cmd = CMD_UNUSED;
            else if (pick < ins_cut)
                it.cmd = CMD_INSERT;
            else if (pick < del_cut)
                it.cmd = CMD_DELETE;
            else
                it.cmd = CMD_DUMP;
            case ($urandom_range(0, 7))
                0:       it.data_in = 32'h8000_0000;
                1:       it.data_in = 32'h7fff_ffff;
                2:       it.data_in = 32'hffff_ffff;
                3:       it.data_in = 32'h0000_0000;
                default: it.data_in = $urandom;
            endcase
            offer_command(it, 1'b0, '0);
        end
        push <= 1'b0;

        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (mismatch_count == 0)
            $display("PASS circular_queue_engine_top");
        else
            $display("FAIL circular_queue_engine_top");
        $finish;
    end

endmodule
